@@ hdl/lfu_pkg.sv @@
// Shared constants and codes for the LFU cache table.
package lfu_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int KEY_W          = 32;
    localparam int DATA_W         = 32;
    localparam int CAP_W          = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic {
        KIND_GET = 1'b0,
        KIND_PUT = 1'b1
    } kind_t;

endpackage

@@ hdl/lfu_cache_table.sv @@
// LFU cache table with LRU tie break: fully associative key-value store.
//
// Takes one get or put transaction per clock unless output backpressure
// stalls it. The request is latched in an input register; from there all
// entries are compared against the key in parallel, a compare tree over the
// entries picks the eviction victim (lowest use count, oldest among equal
// counts), the table is updated and the response is latched in the output
// register. A request passes through the input register and then the output
// register; the tag compare and the victim tree lie on the path between them.
// Keys and values are held in flip-flops; of the table, only the valid bits are reset.
// capacity may be written only while the block is idle; 0 acts as 1 and
// values above ENTRIES act as ENTRIES.
module lfu_cache_table #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0]                  cfg_wdata,  // capacity
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    input  logic [lfu_pkg::KEY_W+lfu_pkg::DATA_W-1:0]  s_tdata,    // key, value
    input  logic                                       s_tuser,    // kind
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [lfu_pkg::DATA_W-1:0]                 m_tdata,    // read_value
    output logic                                       m_tuser     // hit
);
    import lfu_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LEAVES = 1 << IDX_W;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef struct packed {
        logic                  vld;
        logic [COUNT_BITS-1:0] cnt;
        logic [IDX_W-1:0]      rank;
        logic [IDX_W-1:0]      idx;
    } node_t;

    // lower count wins; on equal count the older (higher rank) wins
    function automatic logic better(input node_t a, input node_t b);
        logic r;
        r = a.vld && (!b.vld || (a.cnt < b.cnt) ||
                      ((a.cnt == b.cnt) && (a.rank > b.rank)));
        return r;
    endfunction

    // control and request registers
    logic [CAP_W-1:0]  cap_reg;
    logic              in_valid_reg;
    kind_t             in_kind_reg;
    logic [KEY_W-1:0]  in_key_reg;
    logic [DATA_W-1:0] in_val_reg;
    logic              out_valid_reg;
    logic              out_hit_reg;
    logic [DATA_W-1:0] out_data_reg;

    // table
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic [KEY_W-1:0]      key_reg   [ENTRIES];
    logic [KEY_W-1:0]      key_next  [ENTRIES];
    logic [DATA_W-1:0]     data_reg  [ENTRIES];
    logic [DATA_W-1:0]     data_next [ENTRIES];
    logic [COUNT_BITS-1:0] count_reg [ENTRIES];
    logic [COUNT_BITS-1:0] count_next[ENTRIES];
    logic [IDX_W-1:0]      rank_reg  [ENTRIES];
    logic [IDX_W-1:0]      rank_next [ENTRIES];

    logic               proc;
    logic [ENTRIES-1:0] match;
    logic               hit;
    logic [IDX_W-1:0]   hit_rank;
    logic [DATA_W-1:0]  hit_data;
    logic               do_put;
    logic [CNT_W-1:0]   used;
    logic [CMP_W-1:0]   cap_eff;
    logic               evict;
    logic               ins;
    node_t              node [2*LEAVES];
    logic [ENTRIES-1:0] victim_oh;
    logic [ENTRIES-1:0] valid_after;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] free_oh;
    logic [DATA_W-1:0]  result_data;

    assign proc     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_hit_reg;

    // tag match and hit readout; keys are unique so the OR acts as a mux
    always_comb
    begin
        hit_rank = '0;
        hit_data = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == in_key_reg);
            if (match[i])
            begin
                hit_rank = hit_rank | rank_reg[i];
                hit_data = hit_data | data_reg[i];
            end
        end
        hit = |match;
    end

    // victim selection tree
    always_comb
    begin
        node[0] = '0;
        for (int l = 0; l < LEAVES; l++)
        begin
            if (l < ENTRIES)
            begin
                node[LEAVES+l].vld  = valid_reg[l];
                node[LEAVES+l].cnt  = count_reg[l];
                node[LEAVES+l].rank = rank_reg[l];
            end
            else
            begin
                node[LEAVES+l].vld  = 1'b0;
                node[LEAVES+l].cnt  = '0;
                node[LEAVES+l].rank = '0;
            end
            node[LEAVES+l].idx = IDX_W'(l);
        end
        for (int n = LEAVES - 1; n >= 1; n--)
        begin
            if (better(node[2*n+1], node[2*n]))
                node[n] = node[2*n+1];
            else
                node[n] = node[2*n];
        end
    end

    always_comb
    begin
        used   = CNT_W'($countones(valid_reg));
        do_put = (in_kind_reg == KIND_PUT);
        if (cap_reg == '0)
            cap_eff = CMP_W'(1);
        else if (CMP_W'(cap_reg) > CMP_W'(ENTRIES))
            cap_eff = CMP_W'(ENTRIES);
        else
            cap_eff = CMP_W'(cap_reg);
        evict       = !hit && do_put && (CMP_W'(used) >= cap_eff);
        victim_oh   = evict ? (ENTRIES'(1) << node[1].idx) : '0;
        valid_after = valid_reg & ~victim_oh;
        free_vec    = ~valid_after;
        free_oh     = free_vec & (~free_vec + ENTRIES'(1));
        ins         = !hit && do_put && (|free_vec);
        result_data = (hit && !do_put) ? hit_data : '0;
    end

    // next table contents
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            valid_next[i] = valid_reg[i];
            key_next[i]   = key_reg[i];
            data_next[i]  = data_reg[i];
            count_next[i] = count_reg[i];
            rank_next[i]  = rank_reg[i];
            if (hit)
            begin
                if (match[i])
                begin
                    rank_next[i] = '0;
                    if (count_reg[i] != '1)
                        count_next[i] = count_reg[i] + 1'b1;
                    if (do_put)
                        data_next[i] = in_val_reg;
                end
                else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
            else if (ins)
            begin
                valid_next[i] = valid_after[i] | free_oh[i];
                if (free_oh[i])
                begin
                    key_next[i]   = in_key_reg;
                    data_next[i]  = in_val_reg;
                    count_next[i] = COUNT_BITS'(1);
                    rank_next[i]  = '0;
                end
                else if (valid_after[i])
                begin
                    // close the gap left by the victim, then age by one
                    if (evict && (rank_reg[i] > node[1].rank))
                        rank_next[i] = rank_reg[i];
                    else
                        rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (proc)
                in_valid_reg <= 1'b0;
            if (proc)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (proc)
                valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg <= kind_t'(s_tuser);
            in_key_reg  <= s_tdata[KEY_W-1:0];
            in_val_reg  <= s_tdata[KEY_W+DATA_W-1:KEY_W];
        end
        if (proc)
        begin
            out_hit_reg  <= hit;
            out_data_reg <= result_data;
            for (int i = 0; i < ENTRIES; i++)
            begin
                key_reg[i]   <= key_next[i];
                data_reg[i]  <= data_next[i];
                count_reg[i] <= count_next[i];
                rank_reg[i]  <= rank_next[i];
            end
        end
    end

endmodule

@@ hdl/lfu_checker.sv @@
// Port-level assertions for the LFU cache table, bound to lfu_cache_table.
module lfu_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [lfu_pkg::DATA_W-1:0] m_tdata,
    input logic                       m_tuser
);
    import lfu_pkg::*;

    // a miss never returns data
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("miss transaction returned nonzero data");

    // input side only stalls when both stages are full and output is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    // held response stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("output transaction changed while stalled");

    // output drops only after it was taken
    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_tvalid) |-> $past(m_tready))
        else $error("output transaction dropped without handshake");

endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (.*);
